// ===== hw/rtl/rgba_pixel_blend_assert.svh =====
// Assertion macros for the RGBA pixel blend block.
// Used by rgba_pixel_blend.sv; expects clk_i and rst_ni in scope.
`ifndef RGBA_PIXEL_BLEND_ASSERT_SVH
`define RGBA_PIXEL_BLEND_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define RPB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rgba_pixel_blend: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RPB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rgba_pixel_blend: assertion failed");

`endif

// ===== hw/rtl/rpb_pkg.sv =====
// Shared types and constants for the RGBA pixel blend block.
// No dependencies; used by every rpb_* module and the top level.
package rpb_pkg;

  localparam int unsigned DimW          = 13;
  localparam int unsigned PosW          = 16;
  localparam int unsigned ChanW         = 8;
  localparam int unsigned WeightW       = 9;
  localparam int unsigned ProdW         = 16;
  localparam int unsigned IdxW          = 24;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned CfgDataW      = 13;
  localparam int unsigned InDataW       = 96;
  localparam int unsigned OutDataW      = 64;
  localparam int unsigned NumChan       = 3;
  localparam int unsigned DefaultMaxDim = 4096;

  localparam logic [WeightW-1:0] WeightOne = 9'd256;
  localparam logic [ChanW-1:0]   ChanMax   = 8'd255;

  typedef enum logic [2:0] {
    MODE_NORMAL   = 3'd0,
    MODE_ADD      = 3'd1,
    MODE_SUB      = 3'd2,
    MODE_RSUB     = 3'd3,
    MODE_MODULATE = 3'd4
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH   = 3'd0,
    CFG_HEIGHT  = 3'd1,
    CFG_MODE    = 3'd2,
    CFG_WEIGHT  = 3'd3,
    CFG_USE_SA  = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OUT_WRITTEN = 2'd0,
    OUT_OOB     = 2'd1,
    OUT_SKIPPED = 2'd2
  } outcome_e;

  // Effective settings, already clamped to their legal ranges.
  typedef struct packed {
    logic [DimW-1:0]    width;
    logic [DimW-1:0]    height;
    mode_e              mode;
    logic [WeightW-1:0] weight;
    logic               use_sa;
  } cfg_t;

  typedef struct packed {
    logic [ProdW-1:0] sw;   // source times weight
    logic [ProdW-1:0] dw;   // destination times (one minus weight)
    logic [ProdW-1:0] sd;   // source times destination
    logic [ChanW-1:0] src;
    logic [ChanW-1:0] dst;
  } chan_prod_t;

  typedef struct packed {
    logic                          oob;
    logic [ChanW-1:0]              alpha;
    mode_e                         mode;
    chan_prod_t [NumChan-1:0]      ch;
    logic [ChanW-1:0]              dst_alpha;
    logic [DimW-1:0]               x;
    logic [IdxW-1:0]               yw;
  } s1_t;

  typedef struct packed {
    outcome_e                      outcome;
    logic                          opaque;
    logic [IdxW-1:0]               idx;
    logic [NumChan-1:0][ChanW-1:0] src;
    logic [NumChan-1:0][ChanW-1:0] mix;
    logic [ChanW-1:0]              alpha;
  } s2_t;

  // Result word, lowest field last so the index sits in the low bits.
  typedef struct packed {
    outcome_e         outcome;
    logic [ChanW-1:0] alpha;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
    logic [IdxW-1:0]  idx;
  } result_t;

endpackage

// ===== hw/rtl/rgba_pixel_blend.sv =====
// RGBA pixel blend, top level: one word in, one blended pixel word out. A word
// passes three register stages (products, blend, final select) and is presented
// on the output from the final select register; a new word can be taken every
// cycle, so throughput is one pixel per clock as long as the downstream side
// keeps tready high. Each stage holds its word while the stage after it is full
// and stalled, so backpressure ripples up to s_axis_tready without dropping or
// repeating words. Configuration must be written only while no word is in
// flight.
// Depends on rpb_pkg, rpb_cfg, rpb_prod, rpb_mix and rgba_pixel_blend_assert.svh.
`include "rgba_pixel_blend_assert.svh"

module rgba_pixel_blend #(
  parameter int unsigned MAX_DIM = rpb_pkg::DefaultMaxDim
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rpb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rpb_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // x_pos, y_pos, src_red, src_green, src_blue, src_alpha,
  // dst_red, dst_green, dst_blue, dst_alpha
  input  logic [rpb_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // pixel_index, out_red, out_green, out_blue, out_alpha, outcome, zero pad
  output logic [rpb_pkg::OutDataW-1:0]  m_axis_tdata
);

  rpb_pkg::cfg_t    cfg;
  rpb_pkg::s1_t     s1;
  rpb_pkg::s2_t     s2;
  rpb_pkg::result_t res_d, res_q;
  logic             s1_valid, s2_valid, m_valid_q;
  logic             en1, en2, en3;
  logic             res_written, res_blank;

  assign en3 = !m_valid_q || m_axis_tready;
  assign en2 = !s2_valid || en3;
  assign en1 = !s1_valid || en2;
  assign s_axis_tready = en1;

  rpb_cfg #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  rpb_prod u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en1),
    .valid_i (s_axis_tvalid),
    .data_i  (s_axis_tdata),
    .cfg_i   (cfg),
    .valid_o (s1_valid),
    .s1_o    (s1)
  );

  rpb_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en2),
    .valid_i (s1_valid),
    .s1_i    (s1),
    .valid_o (s2_valid),
    .s2_o    (s2)
  );

  // An opaque source in normal mode replaces the pixel; skipped and out-of-bounds words carry zeros.
  always_comb begin
    res_d.outcome = s2.outcome;
    if (s2.outcome != rpb_pkg::OUT_WRITTEN) begin
      res_d.idx   = '0;
      res_d.red   = '0;
      res_d.green = '0;
      res_d.blue  = '0;
      res_d.alpha = '0;
    end else if (s2.opaque) begin
      res_d.idx   = s2.idx;
      res_d.red   = s2.src[0];
      res_d.green = s2.src[1];
      res_d.blue  = s2.src[2];
      res_d.alpha = rpb_pkg::ChanMax;
    end else begin
      res_d.idx   = s2.idx;
      res_d.red   = s2.mix[0];
      res_d.green = s2.mix[1];
      res_d.blue  = s2.mix[2];
      res_d.alpha = s2.alpha;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en3) begin
      m_valid_q <= s2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(rpb_pkg::OutDataW - $bits(rpb_pkg::result_t)){1'b0}}, res_q};

  assign res_written = (res_q.outcome == rpb_pkg::OUT_WRITTEN);
  assign res_blank   = (res_q.idx == '0) && (res_q.red == '0) && (res_q.green == '0)
                     && (res_q.blue == '0) && (res_q.alpha == '0);

  `RPB_ASSERT(a_stall_only_when_full, !s_axis_tready |-> (s1_valid && s2_valid && m_valid_q))
  `RPB_ASSERT(a_unwritten_is_zero, (m_valid_q && !res_written) |-> res_blank)
  `RPB_ASSERT(a_written_has_alpha, (m_valid_q && res_written) |-> (res_q.alpha != '0))
  `RPB_ASSERT_NEXT(a_mix_holds_on_stall, s2_valid && !en3, s2_valid && $stable(s2))

endmodule

// ===== hw/rtl/rpb_cfg.sv =====
// Configuration registers of the RGBA pixel blend block with range clamping.
// Depends on rpb_pkg.
module rpb_cfg #(
  parameter int unsigned MAX_DIM = rpb_pkg::DefaultMaxDim
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rpb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rpb_pkg::CfgDataW-1:0] cfg_data_i,
  output rpb_pkg::cfg_t                cfg_o
);

  logic [rpb_pkg::DimW-1:0]    width_q, width_d;
  logic [rpb_pkg::DimW-1:0]    height_q, height_d;
  logic [2:0]                  mode_q, mode_d;
  logic [rpb_pkg::WeightW-1:0] weight_q, weight_d;
  logic                        use_sa_q, use_sa_d;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    mode_d   = mode_q;
    weight_d = weight_q;
    use_sa_d = use_sa_q;
    if (cfg_we_i) begin
      unique case (rpb_pkg::cfg_reg_e'(cfg_idx_i))
        rpb_pkg::CFG_WIDTH:  width_d  = cfg_data_i[rpb_pkg::DimW-1:0];
        rpb_pkg::CFG_HEIGHT: height_d = cfg_data_i[rpb_pkg::DimW-1:0];
        rpb_pkg::CFG_MODE:   mode_d   = cfg_data_i[2:0];
        rpb_pkg::CFG_WEIGHT: weight_d = cfg_data_i[rpb_pkg::WeightW-1:0];
        rpb_pkg::CFG_USE_SA: use_sa_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
      mode_q   <= rpb_pkg::MODE_NORMAL;
      weight_q <= rpb_pkg::WeightOne;
      use_sa_q <= 1'b1;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      mode_q   <= mode_d;
      weight_q <= weight_d;
      use_sa_q <= use_sa_d;
    end
  end

  // Sizes above the supported maximum act as the maximum, weights above 256 as 256; unknown modes as normal.
  always_comb begin
    cfg_o.width  = (32'(width_q) > MAX_DIM) ? rpb_pkg::DimW'(MAX_DIM) : width_q;
    cfg_o.height = (32'(height_q) > MAX_DIM) ? rpb_pkg::DimW'(MAX_DIM) : height_q;
    cfg_o.weight = (weight_q > rpb_pkg::WeightOne) ? rpb_pkg::WeightOne : weight_q;
    cfg_o.use_sa = use_sa_q;
    unique case (mode_q)
      rpb_pkg::MODE_ADD:      cfg_o.mode = rpb_pkg::MODE_ADD;
      rpb_pkg::MODE_SUB:      cfg_o.mode = rpb_pkg::MODE_SUB;
      rpb_pkg::MODE_RSUB:     cfg_o.mode = rpb_pkg::MODE_RSUB;
      rpb_pkg::MODE_MODULATE: cfg_o.mode = rpb_pkg::MODE_MODULATE;
      default:                cfg_o.mode = rpb_pkg::MODE_NORMAL;
    endcase
  end

endmodule

// ===== hw/rtl/rpb_prod.sv =====
// First pipeline stage: bounds check, effective alpha and all channel products.
// Depends on rpb_pkg.
module rpb_prod (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [rpb_pkg::InDataW-1:0] data_i,
  input  rpb_pkg::cfg_t               cfg_i,
  output logic                        valid_o,
  output rpb_pkg::s1_t                s1_o
);

  logic                         valid_q;
  rpb_pkg::s1_t                 s1_q, s1_d;
  logic [rpb_pkg::PosW-1:0]     x_raw, y_raw;
  logic [rpb_pkg::ChanW-1:0]    sa_raw, dst_alpha, alpha_src;
  logic [rpb_pkg::WeightW-1:0]  inv_w;
  logic [rpb_pkg::ProdW-1:0]    alpha_prod;
  logic [2*rpb_pkg::DimW-1:0]   yw_full;
  logic [rpb_pkg::ChanW-1:0]    s_ch, d_ch;

  assign x_raw     = data_i[15:0];
  assign y_raw     = data_i[31:16];
  assign sa_raw    = data_i[63:56];
  assign dst_alpha = data_i[95:88];
  assign inv_w     = rpb_pkg::WeightOne - cfg_i.weight;
  assign alpha_src = cfg_i.use_sa ? sa_raw : rpb_pkg::ChanMax;
  assign alpha_prod = {8'd0, alpha_src} * {7'd0, cfg_i.weight};
  // Only in-bounds rows reach the index, and those fit the dimension width.
  assign yw_full   = {{rpb_pkg::DimW{1'b0}}, y_raw[rpb_pkg::DimW-1:0]}
                   * {{rpb_pkg::DimW{1'b0}}, cfg_i.width};

  always_comb begin
    s1_d.oob = x_raw[rpb_pkg::PosW-1] | y_raw[rpb_pkg::PosW-1]
             | (x_raw >= {3'd0, cfg_i.width}) | (y_raw >= {3'd0, cfg_i.height});
    s1_d.alpha     = alpha_prod[15:8];
    s1_d.mode      = cfg_i.mode;
    s1_d.dst_alpha = dst_alpha;
    s1_d.x         = x_raw[rpb_pkg::DimW-1:0];
    s1_d.yw        = yw_full[rpb_pkg::IdxW-1:0];
    for (int i = 0; i < rpb_pkg::NumChan; i++) begin
      s_ch = data_i[32 + 8*i +: 8];
      d_ch = data_i[64 + 8*i +: 8];
      s1_d.ch[i].src = s_ch;
      s1_d.ch[i].dst = d_ch;
      s1_d.ch[i].sw  = {8'd0, s_ch} * {7'd0, cfg_i.weight};
      s1_d.ch[i].dw  = {8'd0, d_ch} * {7'd0, inv_w};
      s1_d.ch[i].sd  = {8'd0, s_ch} * {8'd0, d_ch};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
    end
  end

  assign valid_o = valid_q;
  assign s1_o    = s1_q;

endmodule

// ===== hw/rtl/rpb_mix.sv =====
// Second pipeline stage: per-mode channel blend, alpha sum, index and outcome.
// Depends on rpb_pkg.
module rpb_mix (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  rpb_pkg::s1_t s1_i,
  output logic         valid_o,
  output rpb_pkg::s2_t s2_o
);

  logic                      valid_q;
  rpb_pkg::s2_t              s2_q, s2_d;
  logic [rpb_pkg::ChanW-1:0] sw8, d8, sub_v, rsub_v;
  logic [rpb_pkg::ChanW:0]   add9, alpha9;
  logic [rpb_pkg::ProdW:0]   mod17, nrm17;

  always_comb begin
    s2_d.idx = s1_i.yw + {{(rpb_pkg::IdxW - rpb_pkg::DimW){1'b0}}, s1_i.x};
    alpha9   = {1'b0, s1_i.dst_alpha} + {1'b0, s1_i.alpha};
    s2_d.alpha  = alpha9[8] ? rpb_pkg::ChanMax : alpha9[7:0];
    s2_d.opaque = (s1_i.alpha == rpb_pkg::ChanMax) && (s1_i.mode == rpb_pkg::MODE_NORMAL);
    if (s1_i.oob) begin
      s2_d.outcome = rpb_pkg::OUT_OOB;
    end else if (s1_i.alpha == '0) begin
      s2_d.outcome = rpb_pkg::OUT_SKIPPED;
    end else begin
      s2_d.outcome = rpb_pkg::OUT_WRITTEN;
    end
    for (int i = 0; i < rpb_pkg::NumChan; i++) begin
      sw8    = s1_i.ch[i].sw[15:8];
      d8     = s1_i.ch[i].dst;
      add9   = {1'b0, d8} + {1'b0, sw8};
      sub_v  = (d8 > sw8) ? d8 - sw8 : '0;
      rsub_v = (sw8 > d8) ? sw8 - d8 : '0;
      // Exact divide by 255 for any product of two 8-bit channels.
      mod17  = {1'b0, s1_i.ch[i].sd} + 17'd1 + {9'd0, s1_i.ch[i].sd[15:8]};
      nrm17  = {1'b0, s1_i.ch[i].dw} + {1'b0, s1_i.ch[i].sw};
      s2_d.src[i] = s1_i.ch[i].src;
      case (s1_i.mode)
        rpb_pkg::MODE_ADD:      s2_d.mix[i] = add9[8] ? rpb_pkg::ChanMax : add9[7:0];
        rpb_pkg::MODE_SUB:      s2_d.mix[i] = sub_v;
        rpb_pkg::MODE_RSUB:     s2_d.mix[i] = rsub_v;
        rpb_pkg::MODE_MODULATE: s2_d.mix[i] = mod17[15:8];
        default:                s2_d.mix[i] = nrm17[16] ? rpb_pkg::ChanMax : nrm17[15:8];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q <= s2_d;
    end
  end

  assign valid_o = valid_q;
  assign s2_o    = s2_q;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for rgba_pixel_blend: streams pixel words through the block
// and checks every blended result against a predictor kept inside this module.
// Depends on rpb_pkg and the rgba_pixel_blend RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rpb_pkg::*;

  localparam int unsigned DimLimit = DefaultMaxDim;
  localparam logic [2:0]  ModeUnknown = 3'd7;

  // One input word, highest field first so x_pos lands in the low bits.
  typedef struct packed {
    logic [7:0]         dst_a;
    logic [7:0]         dst_b;
    logic [7:0]         dst_g;
    logic [7:0]         dst_r;
    logic [7:0]         src_a;
    logic [7:0]         src_b;
    logic [7:0]         src_g;
    logic [7:0]         src_r;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } pixel_word_t;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HALF, RX_HEAVY} rx_pattern_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  rgba_pixel_blend u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // Register copies as written, before any clamping.
  logic [12:0] img_width = 13'd0;
  logic [12:0] img_height = 13'd0;
  logic [2:0]  mode_reg = 3'd0;
  logic [8:0]  weight_reg = 9'd256;
  logic        sa_en = 1'b1;

  pixel_word_t pending_pixels[$];
  result_t     expected_blends[$];
  int unsigned mismatches = 0;

  logic        in_taken = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  rx_pattern_e rx_mode = RX_FREE;
  int unsigned rx_left = 0;

  task automatic flag_error(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic logic [7:0] mix_channel(input mode_e m, input int unsigned s,
                                             input int unsigned d, input int unsigned w);
    int unsigned sw;
    int unsigned v;
    sw = (s * w) >> 8;
    case (m)
      MODE_ADD:      v = (d + sw > 255) ? 255 : d + sw;
      MODE_SUB:      v = (d > sw) ? d - sw : 0;
      MODE_RSUB:     v = (sw > d) ? sw - d : 0;
      MODE_MODULATE: v = (s * d) / 255;
      default: begin
        v = (d * (256 - w) + s * w) >> 8;
        if (v > 255) v = 255;
      end
    endcase
    return v[7:0];
  endfunction

  function automatic result_t blend_predict(input pixel_word_t px);
    result_t     r;
    int          xs;
    int          ys;
    int          wd;
    int          ht;
    int unsigned w;
    int unsigned a;
    int unsigned al;
    mode_e       m;
    r  = '0;
    xs = int'(px.x);
    ys = int'(px.y);
    wd = (img_width > DimLimit) ? DimLimit : img_width;
    ht = (img_height > DimLimit) ? DimLimit : img_height;
    w  = (weight_reg > 256) ? 256 : weight_reg;
    m  = (mode_reg > MODE_MODULATE) ? MODE_NORMAL : mode_e'(mode_reg);
    if (xs < 0 || ys < 0 || xs >= wd || ys >= ht) begin
      r.outcome = OUT_OOB;
      return r;
    end
    a = sa_en ? (px.src_a * w) >> 8 : (255 * w) >> 8;
    if (a == 0) begin
      r.outcome = OUT_SKIPPED;
      return r;
    end
    r.outcome = OUT_WRITTEN;
    r.idx = 24'(ys * wd + xs);
    // A fully opaque normal blend simply takes the source colour.
    if (a == 255 && m == MODE_NORMAL) begin
      r.red   = px.src_r;
      r.green = px.src_g;
      r.blue  = px.src_b;
      r.alpha = 8'd255;
    end else begin
      r.red   = mix_channel(m, px.src_r, px.dst_r, w);
      r.green = mix_channel(m, px.src_g, px.dst_g, w);
      r.blue  = mix_channel(m, px.src_b, px.dst_b, w);
      al = px.dst_a + a;
      r.alpha = (al > 255) ? 8'd255 : al[7:0];
    end
    return r;
  endfunction

  // Monitor: predicts each accepted input word and checks each accepted result word.
  always @(posedge clk_i) begin : monitor
    result_t     got;
    result_t     want;
    pixel_word_t px;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        px = s_axis_tdata;
        expected_blends.push_back(blend_predict(px));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(result_t)-1:0];
        if (expected_blends.size() == 0) begin
          flag_error($sformatf("result word %h with nothing expected", m_axis_tdata));
        end else begin
          want = expected_blends.pop_front();
          if (got.idx !== want.idx)
            flag_error($sformatf("pixel_index got %0d want %0d", got.idx, want.idx));
          if (got.red !== want.red)
            flag_error($sformatf("out_red got %0d want %0d", got.red, want.red));
          if (got.green !== want.green)
            flag_error($sformatf("out_green got %0d want %0d", got.green, want.green));
          if (got.blue !== want.blue)
            flag_error($sformatf("out_blue got %0d want %0d", got.blue, want.blue));
          if (got.alpha !== want.alpha)
            flag_error($sformatf("out_alpha got %0d want %0d", got.alpha, want.alpha));
          if (got.outcome !== want.outcome)
            flag_error($sformatf("outcome got %0d want %0d", got.outcome, want.outcome));
        end
      end
    end
  end

  // Driver: bursts of words from the pending queue with random gaps between them.
  always @(negedge clk_i) begin : driver
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_pixels.size() != 0) begin
        s_axis_tdata  <= pending_pixels.pop_front();
        s_axis_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: switches between free flow, light, half and heavy stalling.
  always @(negedge clk_i) begin : receiver
    if (rx_left == 0) begin
      rx_mode <= rx_pattern_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(10, 60);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_FREE:  m_axis_tready <= 1'b1;
      RX_LIGHT: m_axis_tready <= ($urandom_range(0, 3) != 0);
      RX_HALF:  m_axis_tready <= $urandom_range(0, 1);
      default:  m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [12:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_WIDTH:  img_width = data;
      CFG_HEIGHT: img_height = data;
      CFG_MODE:   mode_reg = data[2:0];
      CFG_WEIGHT: weight_reg = data[8:0];
      default:    sa_en = data[0];
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Unused upper data bits carry noise, which the block must ignore.
  task automatic set_config(input logic [12:0] wd, input logic [12:0] ht,
                            input logic [2:0] m, input logic [8:0] w, input logic sa);
    logic [12:0] noise;
    noise = 13'($urandom);
    write_reg(CFG_WIDTH, wd);
    write_reg(CFG_HEIGHT, ht);
    write_reg(CFG_MODE, {noise[12:3], m});
    write_reg(CFG_WEIGHT, {noise[12:9], w});
    write_reg(CFG_USE_SA, {noise[12:1], sa});
  endtask

  // Waits until every word has gone through; the extra cycles cover the pipeline.
  // The queues are looked at on the rising edge, where the driver changes nothing.
  task automatic drain_all();
    while (pending_pixels.size() != 0 || s_axis_tvalid || expected_blends.size() != 0)
      @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic pixel_word_t mk_pixel(input int x, input int y,
                                           input int sr, input int sg, input int sb,
                                           input int sa, input int dr, input int dg,
                                           input int db, input int da);
    pixel_word_t p;
    p.x = x[15:0];
    p.y = y[15:0];
    p.src_r = sr[7:0];
    p.src_g = sg[7:0];
    p.src_b = sb[7:0];
    p.src_a = sa[7:0];
    p.dst_r = dr[7:0];
    p.dst_g = dg[7:0];
    p.dst_b = db[7:0];
    p.dst_a = da[7:0];
    return p;
  endfunction

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly inside the image, with boundaries and arbitrary values mixed in.
  function automatic logic [15:0] rand_pos(input logic [12:0] reg_dim);
    int lim;
    lim = (reg_dim > DimLimit) ? DimLimit : reg_dim;
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: begin
        case ($urandom_range(0, 5))
          0:       return 16'hffff;
          1:       return 16'(lim);
          2:       return 16'(lim - 1);
          3:       return 16'h8000;
          4:       return 16'h7fff;
          default: return 16'h0000;
        endcase
      end
      default: return (lim > 0) ? 16'($urandom_range(0, lim - 1)) : 16'($urandom);
    endcase
  endfunction

  function automatic pixel_word_t rand_pixel();
    pixel_word_t p;
    p.x = rand_pos(img_width);
    p.y = rand_pos(img_height);
    p.src_r = rand_chan();
    p.src_g = rand_chan();
    p.src_b = rand_chan();
    p.src_a = rand_chan();
    p.dst_r = rand_chan();
    p.dst_g = rand_chan();
    p.dst_b = rand_chan();
    p.dst_a = rand_chan();
    return p;
  endfunction

  initial begin : stimulus
    logic [12:0] dims[6];
    logic [8:0]  weights[8];
    logic [12:0] wd;
    logic [12:0] ht;
    logic [8:0]  w;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings give a zero-sized image, so everything is out of bounds.
    pending_pixels.push_back(mk_pixel(0, 0, 1, 2, 3, 255, 4, 5, 6, 7));
    pending_pixels.push_back(mk_pixel(-1, 5, 255, 255, 255, 255, 0, 0, 0, 0));
    drain_all();

    set_config(13'd64, 13'd32, MODE_NORMAL, 9'd256, 1'b1);
    pending_pixels.push_back(mk_pixel(3, 4, 10, 20, 30, 255, 200, 100, 50, 0));
    pending_pixels.push_back(mk_pixel(5, 6, 10, 20, 30, 0, 200, 100, 50, 9));
    pending_pixels.push_back(mk_pixel(0, 0, 255, 0, 255, 128, 0, 255, 0, 255));
    pending_pixels.push_back(mk_pixel(63, 31, 0, 255, 0, 1, 255, 0, 255, 0));
    pending_pixels.push_back(mk_pixel(64, 0, 9, 9, 9, 255, 9, 9, 9, 9));
    pending_pixels.push_back(mk_pixel(0, 32, 9, 9, 9, 255, 9, 9, 9, 9));
    pending_pixels.push_back(mk_pixel(0, -1, 9, 9, 9, 255, 9, 9, 9, 9));
    pending_pixels.push_back(mk_pixel(-32768, 32767, 9, 9, 9, 255, 9, 9, 9, 9));
    pending_pixels.push_back(mk_pixel(32767, -32768, 9, 9, 9, 255, 9, 9, 9, 9));
    pending_pixels.push_back(mk_pixel(32767, 32767, 9, 9, 9, 255, 9, 9, 9, 9));
    drain_all();

    for (int m = MODE_ADD; m <= MODE_MODULATE; m++) begin
      set_config(13'd64, 13'd32, 3'(m), 9'd128, 1'b1);
      pending_pixels.push_back(mk_pixel(10, 5, 255, 0, 128, 255, 0, 255, 128, 200));
      pending_pixels.push_back(mk_pixel(63, 0, 200, 100, 50, 128, 100, 200, 250, 255));
      drain_all();
    end
    // An unknown mode with an oversized weight and alpha taken from the weight alone.
    set_config(13'd8191, 13'd8191, ModeUnknown, 9'd511, 1'b0);
    pending_pixels.push_back(mk_pixel(4095, 4095, 7, 8, 9, 0, 250, 251, 252, 253));
    drain_all();

    dims    = '{13'd1, 13'd4096, 13'd8191, 13'd4097, 13'd300, 13'd0};
    weights = '{9'd256, 9'd0, 9'd1, 9'd128, 9'd255, 9'd257, 9'd511, 9'd0};
    for (int p = 0; p < 14; p++) begin
      wd = dims[p % 6];
      ht = dims[(p + 2) % 6];
      if (wd == 13'd0 || p % 5 == 4) wd = 13'($urandom_range(2, 80));
      if (ht == 13'd0) ht = 13'($urandom_range(2, 80));
      w = weights[(p * 3) % 8];
      if ((p * 3) % 8 == 7) w = 9'($urandom_range(0, 511));
      set_config(wd, ht, 3'(p % 8), w, (p / 2) % 2 == 0);
      for (int i = 0; i < 60; i++) pending_pixels.push_back(rand_pixel());
      // The sender holds off here until every expected result has arrived.
      drain_all();
    end

    repeat (10) @(negedge clk_i);
    if (mismatches == 0 && expected_blends.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/rpb_pkg.sv
hw/rtl/rpb_cfg.sv
hw/rtl/rpb_prod.sv
hw/rtl/rpb_mix.sv
hw/rtl/rgba_pixel_blend.sv
tb/tb.sv
